>>> hdl/chc_pkg.sv
// ----------------------------------------------------------------------------
// chc_pkg
// Shared constants, types and decode functions for the cartridge header
// checker: header offsets, logo bytes, cartridge type and size decoding.
// ----------------------------------------------------------------------------
package chc_pkg;

   localparam int OffsetWidth = 9;
   localparam int ByteWidth   = 8;
   localparam int RomKibWidth = 14;
   localparam int BanksWidth  = 5;
   localparam int LogoIdxWidth = 6;

   // size of one external ram bank in bytes
   localparam int RAM_BANK_BYTES = 8192;

   localparam logic [OffsetWidth-1:0] LogoFirst      = 9'h104;
   localparam logic [OffsetWidth-1:0] LogoLast       = 9'h133;
   localparam logic [OffsetWidth-1:0] SumFirst       = 9'h134;
   localparam logic [OffsetWidth-1:0] SumLast        = 9'h14C;
   localparam logic [OffsetWidth-1:0] ChecksumOffset = 9'h14D;
   localparam logic [OffsetWidth-1:0] TypeOffset     = 9'h147;
   localparam logic [OffsetWidth-1:0] ColorOffset    = 9'h143;
   localparam logic [OffsetWidth-1:0] SuperOffset    = 9'h146;
   localparam logic [OffsetWidth-1:0] RomSizeOffset  = 9'h148;
   localparam logic [OffsetWidth-1:0] RamSizeOffset  = 9'h149;

   localparam logic [ByteWidth-1:0] ColorCompat = 8'h80;
   localparam logic [ByteWidth-1:0] ColorOnly   = 8'hC0;
   localparam logic [ByteWidth-1:0] SuperCode   = 8'h03;
   localparam logic [ByteWidth-1:0] RomCodeMax  = 8'h08;
   localparam logic [RomKibWidth-1:0] RomKibBase = 14'd32;

   typedef enum logic [3:0] {
      MapRom    = 4'd0,
      MapMbc1   = 4'd1,
      MapMbc2   = 4'd2,
      MapMbc3   = 4'd3,
      MapMbc5   = 4'd4,
      MapMbc6   = 4'd5,
      MapMmm01  = 4'd6,
      MapCamera = 4'd7,
      MapTama5  = 4'd8,
      MapHuc3   = 4'd9,
      MapHuc1   = 4'd10,
      MapUnknown = 4'd11
   } mapper_kind_type;

   typedef enum logic [1:0] {
      ModeDmg   = 2'd0,
      ModeColor = 2'd1,
      ModeSuper = 2'd2
   } console_mode_type;

   typedef struct packed {
      logic sensor;
      logic rumble;
      logic timer;
      logic battery;
      logic ram;
   } cart_flags_type;

   typedef struct packed {
      mapper_kind_type kind;
      cart_flags_type  flags;
   } cart_type_type;

   // bank counts per ram size code, worked out at elaboration
   localparam int RamBanks1Raw = 32'h800   / RAM_BANK_BYTES;
   localparam int RamBanks2Raw = 32'h2000  / RAM_BANK_BYTES;
   localparam int RamBanks3Raw = 32'h8000  / RAM_BANK_BYTES;
   localparam int RamBanks4Raw = 32'h20000 / RAM_BANK_BYTES;
   localparam int RamBanks5Raw = 32'h10000 / RAM_BANK_BYTES;
   localparam int BanksMax = (1 << BanksWidth) - 1;
   localparam logic [BanksWidth-1:0] RamBanks1 =
      (RamBanks1Raw > BanksMax) ? BanksWidth'(BanksMax) : BanksWidth'(RamBanks1Raw);
   localparam logic [BanksWidth-1:0] RamBanks2 =
      (RamBanks2Raw > BanksMax) ? BanksWidth'(BanksMax) : BanksWidth'(RamBanks2Raw);
   localparam logic [BanksWidth-1:0] RamBanks3 =
      (RamBanks3Raw > BanksMax) ? BanksWidth'(BanksMax) : BanksWidth'(RamBanks3Raw);
   localparam logic [BanksWidth-1:0] RamBanks4 =
      (RamBanks4Raw > BanksMax) ? BanksWidth'(BanksMax) : BanksWidth'(RamBanks4Raw);
   localparam logic [BanksWidth-1:0] RamBanks5 =
      (RamBanks5Raw > BanksMax) ? BanksWidth'(BanksMax) : BanksWidth'(RamBanks5Raw);

   function automatic logic [ByteWidth-1:0] logo_byte(input logic [LogoIdxWidth-1:0] idx);
      logic [ByteWidth-1:0] b;
      case (idx)
         6'd0:  b = 8'hCE;  6'd1:  b = 8'hED;  6'd2:  b = 8'h66;  6'd3:  b = 8'h66;
         6'd4:  b = 8'hCC;  6'd5:  b = 8'h0D;  6'd6:  b = 8'h00;  6'd7:  b = 8'h0B;
         6'd8:  b = 8'h03;  6'd9:  b = 8'h73;  6'd10: b = 8'h00;  6'd11: b = 8'h83;
         6'd12: b = 8'h00;  6'd13: b = 8'h0C;  6'd14: b = 8'h00;  6'd15: b = 8'h0D;
         6'd16: b = 8'h00;  6'd17: b = 8'h08;  6'd18: b = 8'h11;  6'd19: b = 8'h1F;
         6'd20: b = 8'h88;  6'd21: b = 8'h89;  6'd22: b = 8'h00;  6'd23: b = 8'h0E;
         6'd24: b = 8'hDC;  6'd25: b = 8'hCC;  6'd26: b = 8'h6E;  6'd27: b = 8'hE6;
         6'd28: b = 8'hDD;  6'd29: b = 8'hDD;  6'd30: b = 8'hD9;  6'd31: b = 8'h99;
         6'd32: b = 8'hBB;  6'd33: b = 8'hBB;  6'd34: b = 8'h67;  6'd35: b = 8'h63;
         6'd36: b = 8'h6E;  6'd37: b = 8'h0E;  6'd38: b = 8'hEC;  6'd39: b = 8'hCC;
         6'd40: b = 8'hDD;  6'd41: b = 8'hDC;  6'd42: b = 8'h99;  6'd43: b = 8'h9F;
         6'd44: b = 8'hBB;  6'd45: b = 8'hB9;  6'd46: b = 8'h33;  6'd47: b = 8'h3E;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic cart_type_type decode_type(input logic [ByteWidth-1:0] t);
      cart_type_type r;
      r.kind  = MapUnknown;
      r.flags = '0;
      case (t)
         8'h00: r.kind = MapRom;
         8'h01: r.kind = MapMbc1;
         8'h02: begin r.kind = MapMbc1; r.flags = 5'b00001; end
         8'h03: begin r.kind = MapMbc1; r.flags = 5'b00011; end
         8'h05: r.kind = MapMbc2;
         8'h06: begin r.kind = MapMbc2; r.flags = 5'b00010; end
         8'h08: begin r.kind = MapRom; r.flags = 5'b00001; end
         8'h09: begin r.kind = MapRom; r.flags = 5'b00011; end
         8'h0B: r.kind = MapMmm01;
         8'h0C: begin r.kind = MapMmm01; r.flags = 5'b00001; end
         8'h0D: begin r.kind = MapMmm01; r.flags = 5'b00011; end
         8'h0F: begin r.kind = MapMbc3; r.flags = 5'b00110; end
         8'h10: begin r.kind = MapMbc3; r.flags = 5'b00111; end
         8'h11: r.kind = MapMbc3;
         8'h12: begin r.kind = MapMbc3; r.flags = 5'b00001; end
         8'h13: begin r.kind = MapMbc3; r.flags = 5'b00011; end
         8'h19: r.kind = MapMbc5;
         8'h1A: begin r.kind = MapMbc5; r.flags = 5'b00001; end
         8'h1B: begin r.kind = MapMbc5; r.flags = 5'b00011; end
         8'h1C: begin r.kind = MapMbc5; r.flags = 5'b01000; end
         8'h1D: begin r.kind = MapMbc5; r.flags = 5'b01001; end
         8'h1E: begin r.kind = MapMbc5; r.flags = 5'b01011; end
         8'h20: r.kind = MapMbc6;
         // mbc7 style cart, reported as mbc5 with sensor, rumble, battery and ram
         8'h22: begin r.kind = MapMbc5; r.flags = 5'b11011; end
         8'hFC: r.kind = MapCamera;
         8'hFD: r.kind = MapTama5;
         8'hFE: r.kind = MapHuc3;
         8'hFF: begin r.kind = MapHuc1; r.flags = 5'b00011; end
         default: begin r.kind = MapUnknown; r.flags = '0; end
      endcase
      return r;
   endfunction

   function automatic logic [BanksWidth-1:0] ram_banks(input logic [ByteWidth-1:0] code);
      logic [BanksWidth-1:0] n;
      case (code)
         8'd1:    n = RamBanks1;
         8'd2:    n = RamBanks2;
         8'd3:    n = RamBanks3;
         8'd4:    n = RamBanks4;
         8'd5:    n = RamBanks5;
         default: n = '0;
      endcase
      return n;
   endfunction

endpackage

>>> hdl/cartridge_header_checker_core.sv
// ----------------------------------------------------------------------------
// cartridge_header_checker_core
// Checks a cartridge header streamed as offset/byte requests and reports
// logo and checksum status together with the decoded header fields.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one rom byte of bank 0 with its offset, in any order.
//   Offsets outside the header are dropped. The request marked req_last
//   closes the header: one report then appears on rsp_*, and all header
//   state returns to its reset value for the next cartridge.
//   Requests pass through an input register and combinational decode logic
//   into the report register, which is loaded as the last request leaves the
//   input register. One request is accepted every cycle while req_ready is high.
//   When rsp_ready is low, non-last requests keep flowing; a last request
//   waits in the input register until the held report is taken, so req_ready
//   drops only in that case.
//   Reset (synchronous, active high) empties both registers, drops
//   rsp_valid and restores the header state: logo ok, checksum zero,
//   type and size bytes zero, mode flags clear.
// ----------------------------------------------------------------------------
module cartridge_header_checker_core
   import chc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OffsetWidth-1:0] req_offset,
   input  logic [ByteWidth-1:0]   req_data_byte,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_header_valid,
   output logic                   rsp_logo_match,
   output logic                   rsp_checksum_match,
   output logic [3:0]             rsp_mapper_kind,
   output logic                   rsp_has_ram,
   output logic                   rsp_with_battery,
   output logic                   rsp_with_timer,
   output logic                   rsp_with_rumble,
   output logic                   rsp_with_sensor,
   output logic [1:0]             rsp_console_mode,
   output logic [RomKibWidth-1:0] rsp_rom_kib,
   output logic [BanksWidth-1:0]  rsp_ram_banks
);

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic [OffsetWidth-1:0] in_offset_ff;
   logic [ByteWidth-1:0]   in_data_ff;
   logic                   in_last_ff;
   logic                   advance;

   // header state
   logic                 logo_ok_ff, logo_ok_in;
   logic [ByteWidth-1:0] sum_ff, sum_in;
   logic [ByteWidth-1:0] checksum_ff, checksum_in;
   logic                 color_ff, color_in;
   logic                 super_ff, super_in;
   logic [ByteWidth-1:0] type_ff, type_in;
   logic [ByteWidth-1:0] rom_code_ff, rom_code_in;
   logic [ByteWidth-1:0] ram_code_ff, ram_code_in;

   // report register
   logic                   out_valid_ff, out_valid_in;
   logic                   logo_match_ff, logo_match_in;
   logic                   sum_match_ff, sum_match_in;
   cart_type_type          cart_ff, cart_in;
   console_mode_type       mode_ff, mode_in;
   logic [RomKibWidth-1:0] rom_kib_ff, rom_kib_in;
   logic [BanksWidth-1:0]  banks_ff, banks_in;

   logic [OffsetWidth-1:0] logo_rel;

   // a last request needs the report register free
   assign advance   = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign logo_rel  = in_offset_ff - LogoFirst;

   always_comb begin
      logo_ok_in  = logo_ok_ff;
      sum_in      = sum_ff;
      checksum_in = checksum_ff;
      color_in    = color_ff;
      super_in    = super_ff;
      type_in     = type_ff;
      rom_code_in = rom_code_ff;
      ram_code_in = ram_code_ff;

      if (in_offset_ff >= LogoFirst && in_offset_ff <= LogoLast) begin
         if (in_data_ff != logo_byte(logo_rel[LogoIdxWidth-1:0])) begin
            logo_ok_in = 1'b0;
         end
      end
      if (in_offset_ff >= SumFirst && in_offset_ff <= SumLast) begin
         sum_in = sum_ff - in_data_ff - 8'd1;
      end
      case (in_offset_ff)
         ChecksumOffset: checksum_in = in_data_ff;
         ColorOffset:    color_in = in_data_ff inside {ColorCompat, ColorOnly};
         SuperOffset:    super_in = (in_data_ff == SuperCode);
         TypeOffset:     type_in = in_data_ff;
         RomSizeOffset:  rom_code_in = in_data_ff;
         RamSizeOffset:  ram_code_in = in_data_ff;
         default: ;
      endcase
   end

   // report built from the state including the closing request
   always_comb begin
      logo_match_in = logo_ok_in;
      sum_match_in  = (sum_in == checksum_in);
      cart_in       = decode_type(type_in);
      if (super_in) begin
         mode_in = ModeSuper;
      end else if (color_in) begin
         mode_in = ModeColor;
      end else begin
         mode_in = ModeDmg;
      end
      rom_kib_in = (rom_code_in <= RomCodeMax) ? (RomKibBase << rom_code_in[3:0]) : '0;
      banks_in   = ram_banks(ram_code_in);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         logo_ok_ff   <= 1'b1;
         sum_ff       <= '0;
         checksum_ff  <= '0;
         color_ff     <= 1'b0;
         super_ff     <= 1'b0;
         type_ff      <= '0;
         rom_code_ff  <= '0;
         ram_code_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            if (in_last_ff) begin
               // header done: back to reset values
               logo_ok_ff  <= 1'b1;
               sum_ff      <= '0;
               checksum_ff <= '0;
               color_ff    <= 1'b0;
               super_ff    <= 1'b0;
               type_ff     <= '0;
               rom_code_ff <= '0;
               ram_code_ff <= '0;
            end else begin
               logo_ok_ff  <= logo_ok_in;
               sum_ff      <= sum_in;
               checksum_ff <= checksum_in;
               color_ff    <= color_in;
               super_ff    <= super_in;
               type_ff     <= type_in;
               rom_code_ff <= rom_code_in;
               ram_code_ff <= ram_code_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_offset_ff <= req_offset;
         in_data_ff   <= req_data_byte;
         in_last_ff   <= req_last;
      end
      if (advance && in_last_ff) begin
         logo_match_ff <= logo_match_in;
         sum_match_ff  <= sum_match_in;
         cart_ff       <= cart_in;
         mode_ff       <= mode_in;
         rom_kib_ff    <= rom_kib_in;
         banks_ff      <= banks_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_header_valid   = logo_match_ff && sum_match_ff;
   assign rsp_logo_match     = logo_match_ff;
   assign rsp_checksum_match = sum_match_ff;
   assign rsp_mapper_kind    = cart_ff.kind;
   assign rsp_has_ram        = cart_ff.flags.ram;
   assign rsp_with_battery   = cart_ff.flags.battery;
   assign rsp_with_timer     = cart_ff.flags.timer;
   assign rsp_with_rumble    = cart_ff.flags.rumble;
   assign rsp_with_sensor    = cart_ff.flags.sensor;
   assign rsp_console_mode   = mode_ff;
   assign rsp_rom_kib        = rom_kib_ff;
   assign rsp_ram_banks      = banks_ff;

endmodule

>>> hdl/chc_checker.sv
// ----------------------------------------------------------------------------
// chc_checker
// Port level checks for the cartridge header checker, bound to the core.
// ----------------------------------------------------------------------------
module chc_checker
   import chc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_last,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_header_valid,
   input logic                   rsp_logo_match,
   input logic                   rsp_checksum_match,
   input logic [3:0]             rsp_mapper_kind,
   input logic [1:0]             rsp_console_mode
);

   // a report is never dropped while held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("report dropped before taken");

   // nothing reported straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("report present after reset");

   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_header_valid == (rsp_logo_match && rsp_checksum_match))
      else $error("header_valid disagrees with match flags");

   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_console_mode <= ModeSuper) && (rsp_mapper_kind <= MapUnknown))
      else $error("report code out of range");

   // a report needs a closing request accepted earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2) ||
                           $past(rsp_valid && rsp_ready))
      else $error("report without a closing request");

endmodule

bind cartridge_header_checker_core chc_checker u_chc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_last           (req_last),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_header_valid   (rsp_header_valid),
   .rsp_logo_match     (rsp_logo_match),
   .rsp_checksum_match (rsp_checksum_match),
   .rsp_mapper_kind    (rsp_mapper_kind),
   .rsp_console_mode   (rsp_console_mode)
);
